[sv/bse_pkg.sv]
// Package with request/response types, command and op codes, and helpers for the byte set engine.
package bse_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_APPEND  = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_COMBINE = 3'd4;
  localparam logic [2:0] CMD_COMPARE = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [1:0] OP_AND    = 2'd0;
  localparam logic [1:0] OP_OR     = 2'd1;
  localparam logic [1:0] OP_DIFF   = 2'd2;
  localparam logic [1:0] OP_SUBSET = 2'd0;
  localparam logic [1:0] OP_EQUAL  = 2'd1;
  localparam logic [1:0] OP_PROPER = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam int WORD_W = 64;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] slot_a;
    logic [1:0] slot_b;
    logic [1:0] dest_slot;
    logic [1:0] op;
    logic [7:0] value;
    logic [1:0] word_index;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        flag;
    logic [8:0]  count;
    logic [63:0] member_word;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_CLEAR,
    S_SWEEP,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_t;

  function automatic logic [6:0] pop64(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + 7'(x[i]);
    end
    return n;
  endfunction

endpackage

[sv/bse_req_if.sv]
// Request channel interface for the byte set engine.
interface bse_req_if;
  logic          valid;
  logic          ready;
  bse_pkg::req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/bse_rsp_if.sv]
// Response channel interface for the byte set engine.
interface bse_rsp_if;
  logic          valid;
  logic          ready;
  bse_pkg::rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/byte_set_engine_unit.sv]
// Byte set engine: 256-bit membership maps in word memory with counts, one request at a time.
// Steps: insert/append/remove/read a read-modify-write state, clear a write per word, compare
// and combine 4 sweeps and evaluate, combine then 4 writes unless it overflows; then done.
// Throughput: one request in flight; the next is taken the cycle after the response loads.
// The map and count memories have one write port; each word is swept once per operand.
// Reset clears control and per-entry valid bits, so every set reads as empty at once.
module byte_set_engine_unit #(
  parameter int NUM_SETS = 4,
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  bse_req_if.sink    req,
  bse_rsp_if.source  rsp
);

  localparam int DEPTH  = NUM_SETS * 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam logic [4:0] NSETS = 5'(NUM_SETS);
  localparam logic [8:0] CAP   = 9'(CAPACITY);

  function automatic logic [ADDR_W-1:0] word_addr(input logic [1:0] s, input logic [1:0] w);
    return ADDR_W'({s, w});
  endfunction

  function automatic logic slot_ok(input logic [1:0] s);
    return 5'(s) < NSETS;
  endfunction

  // memories
  logic [63:0] mem [DEPTH];
  logic [DEPTH-1:0] mem_vld;
  logic [8:0] cmem [NUM_SETS];
  logic [NUM_SETS-1:0] cmem_vld;

  logic              rd_en, cnt_rd_en, we, cnt_we;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [SW-1:0]     cnt_addr_a, cnt_addr_b, cnt_waddr;
  logic [63:0]       wr_data;
  logic [8:0]        cnt_wdata;

  logic [63:0] rd_a_raw, rd_b_raw, rd_a, rd_b;
  logic        rd_a_ok, rd_b_ok, cnt_a_ok, cnt_b_ok;
  logic [8:0]  cnt_a_raw, cnt_b_raw, cnt_a, cnt_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_raw <= mem[rd_addr_a];
      rd_b_raw <= mem[rd_addr_b];
    end
    if (cnt_we) begin
      cmem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_rd_en) begin
      cnt_a_raw <= cmem[cnt_addr_a];
      cnt_b_raw <= cmem[cnt_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld  <= '0;
      cmem_vld <= '0;
      rd_a_ok  <= 1'b0;
      rd_b_ok  <= 1'b0;
      cnt_a_ok <= 1'b0;
      cnt_b_ok <= 1'b0;
    end else begin
      if (we) begin
        mem_vld[wr_addr] <= 1'b1;
      end
      if (cnt_we) begin
        cmem_vld[cnt_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_a_ok <= mem_vld[rd_addr_a];
        rd_b_ok <= mem_vld[rd_addr_b];
      end
      if (cnt_rd_en) begin
        cnt_a_ok <= cmem_vld[cnt_addr_a];
        cnt_b_ok <= cmem_vld[cnt_addr_b];
      end
    end
  end

  assign rd_a  = rd_a_ok ? rd_a_raw : '0;
  assign rd_b  = rd_b_ok ? rd_b_raw : '0;
  assign cnt_a = cnt_a_ok ? cnt_a_raw : '0;
  assign cnt_b = cnt_b_ok ? cnt_b_raw : '0;

  // control
  bse_pkg::state_t state, state_next;
  logic [1:0] idx, idx_next;
  logic [2:0] cmd_r;
  logic [1:0] a_r, b_r, d_r, op_r;
  logic [7:0] val_r;

  logic        res_status, res_status_next, res_flag, res_flag_next;
  logic [8:0]  res_count, res_count_next;
  logic [63:0] res_word, res_word_next;

  logic        sub_acc, same_acc;
  logic [8:0]  n_acc;
  logic [63:0] r_buf [4];

  logic        accept, bad, out_load;
  logic [1:0]  rd_sel;
  logic [63:0] comb_word, bit_mask;
  logic [6:0]  comb_pop;
  logic        present, full;

  assign req.ready = (state == bse_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    case (op_r)
      bse_pkg::OP_AND: comb_word = rd_a & rd_b;
      bse_pkg::OP_OR:  comb_word = rd_a | rd_b;
      default:         comb_word = rd_a & ~rd_b;
    endcase
  end

  assign comb_pop = bse_pkg::pop64(comb_word);
  assign bit_mask = 64'(1) << val_r[5:0];
  assign present  = rd_a[val_r[5:0]];
  assign full     = cnt_a >= CAP;

  always_comb begin
    case (req.data.command)
      bse_pkg::CMD_CLEAR, bse_pkg::CMD_INSERT, bse_pkg::CMD_APPEND, bse_pkg::CMD_REMOVE,
      bse_pkg::CMD_READ: bad = !slot_ok(req.data.slot_a);
      bse_pkg::CMD_COMPARE: bad = !slot_ok(req.data.slot_a) || !slot_ok(req.data.slot_b);
      bse_pkg::CMD_COMBINE: bad = !slot_ok(req.data.slot_a) || !slot_ok(req.data.slot_b) ||
                                  !slot_ok(req.data.dest_slot);
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    case (req.data.command)
      bse_pkg::CMD_READ:                         rd_sel = req.data.word_index;
      bse_pkg::CMD_COMBINE, bse_pkg::CMD_COMPARE: rd_sel = 2'd0;
      default:                                   rd_sel = req.data.value[7:6];
    endcase
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    res_status_next = res_status;
    res_flag_next   = res_flag;
    res_count_next  = res_count;
    res_word_next   = res_word;
    rd_en      = 1'b0;
    cnt_rd_en  = 1'b0;
    rd_addr_a  = word_addr(req.data.slot_a, rd_sel);
    rd_addr_b  = word_addr(req.data.slot_b, 2'd0);
    cnt_addr_a = SW'(req.data.command == bse_pkg::CMD_COMBINE ?
                     req.data.dest_slot : req.data.slot_a);
    cnt_addr_b = SW'(req.data.slot_b);
    we         = 1'b0;
    wr_addr    = word_addr(a_r, val_r[7:6]);
    wr_data    = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = SW'(a_r);
    cnt_wdata  = '0;
    out_load   = 1'b0;

    case (state)
      bse_pkg::S_IDLE: begin
        if (accept) begin
          rd_en           = 1'b1;
          cnt_rd_en       = 1'b1;
          idx_next        = 2'd0;
          res_status_next = bad;
          res_flag_next   = 1'b0;
          res_count_next  = '0;
          res_word_next   = '0;
          if (bad) begin
            state_next = bse_pkg::S_DONE;
          end else begin
            case (req.data.command)
              bse_pkg::CMD_CLEAR: state_next = bse_pkg::S_CLEAR;
              bse_pkg::CMD_COMBINE, bse_pkg::CMD_COMPARE: begin
                state_next = (req.data.op == bse_pkg::OP_BAD) ? bse_pkg::S_EVAL
                                                              : bse_pkg::S_SWEEP;
              end
              default: state_next = bse_pkg::S_RMW;
            endcase
          end
        end
      end

      bse_pkg::S_RMW: begin
        res_count_next = cnt_a;
        case (cmd_r)
          bse_pkg::CMD_INSERT: begin
            if (!present) begin
              if (full) begin
                res_status_next = 1'b1;
              end else begin
                we             = 1'b1;
                wr_data        = rd_a | bit_mask;
                cnt_we         = 1'b1;
                cnt_wdata      = cnt_a + 9'd1;
                res_count_next = cnt_a + 9'd1;
              end
            end
          end
          bse_pkg::CMD_APPEND: begin
            if (full) begin
              res_status_next = 1'b1;
            end else if (!present) begin
              we             = 1'b1;
              wr_data        = rd_a | bit_mask;
              cnt_we         = 1'b1;
              cnt_wdata      = cnt_a + 9'd1;
              res_count_next = cnt_a + 9'd1;
            end
          end
          bse_pkg::CMD_REMOVE: begin
            if (present) begin
              we             = 1'b1;
              wr_data        = rd_a & ~bit_mask;
              cnt_we         = 1'b1;
              cnt_wdata      = cnt_a - 9'd1;
              res_count_next = cnt_a - 9'd1;
            end
          end
          default: res_word_next = rd_a;
        endcase
        state_next = bse_pkg::S_DONE;
      end

      bse_pkg::S_CLEAR: begin
        we      = 1'b1;
        wr_addr = word_addr(a_r, idx);
        if (idx == 2'd0) begin
          cnt_we = 1'b1;
        end
        idx_next = idx + 2'd1;
        if (idx == 2'd3) begin
          state_next = bse_pkg::S_DONE;
        end
      end

      bse_pkg::S_SWEEP: begin
        rd_en     = (idx != 2'd3);
        rd_addr_a = word_addr(a_r, idx + 2'd1);
        rd_addr_b = word_addr(b_r, idx + 2'd1);
        idx_next  = idx + 2'd1;
        if (idx == 2'd3) begin
          state_next = bse_pkg::S_EVAL;
        end
      end

      bse_pkg::S_EVAL: begin
        res_count_next = cnt_a;
        state_next     = bse_pkg::S_DONE;
        if (cmd_r == bse_pkg::CMD_COMBINE) begin
          if (op_r == bse_pkg::OP_BAD || n_acc > CAP) begin
            res_status_next = 1'b1;
          end else begin
            res_count_next = n_acc;
            idx_next       = 2'd0;
            state_next     = bse_pkg::S_WRITE;
          end
        end else begin
          case (op_r)
            bse_pkg::OP_SUBSET: res_flag_next = sub_acc;
            bse_pkg::OP_EQUAL:  res_flag_next = same_acc && (cnt_a == cnt_b);
            bse_pkg::OP_PROPER: res_flag_next = sub_acc && (cnt_a < cnt_b);
            default:            res_status_next = 1'b1;
          endcase
        end
      end

      bse_pkg::S_WRITE: begin
        we        = 1'b1;
        wr_addr   = word_addr(d_r, idx);
        wr_data   = r_buf[idx];
        cnt_waddr = SW'(d_r);
        cnt_wdata = n_acc;
        if (idx == 2'd0) begin
          cnt_we = 1'b1;
        end
        idx_next = idx + 2'd1;
        if (idx == 2'd3) begin
          state_next = bse_pkg::S_DONE;
        end
      end

      bse_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = bse_pkg::S_IDLE;
        end
      end

      default: state_next = bse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bse_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_flag   <= res_flag_next;
    res_count  <= res_count_next;
    res_word   <= res_word_next;
    if (accept) begin
      cmd_r    <= req.data.command;
      a_r      <= req.data.slot_a;
      b_r      <= req.data.slot_b;
      d_r      <= req.data.dest_slot;
      op_r     <= req.data.op;
      val_r    <= req.data.value;
      n_acc    <= '0;
      sub_acc  <= 1'b1;
      same_acc <= 1'b1;
    end else if (state == bse_pkg::S_SWEEP) begin
      r_buf[idx] <= comb_word;
      n_acc      <= n_acc + 9'(comb_pop);
      if ((rd_a & ~rd_b) != '0) begin
        sub_acc <= 1'b0;
      end
      if (rd_a != rd_b) begin
        same_acc <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.data.status      <= res_status;
      rsp.data.flag        <= res_flag;
      rsp.data.count       <= res_count;
      rsp.data.member_word <= res_word;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> cnt_wdata <= CAP)
    else $error("count written above capacity");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == bse_pkg::S_DONE)
    else $error("response raised outside done state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != bse_pkg::S_IDLE)
    else $error("request accepted without leaving idle");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> !accept)
    else $error("map write while accepting a request");
`endif

endmodule

[sim/bse_checker.sv]
// Checker for the byte set engine: tracks the set slots, predicts every response and compares.
module bse_checker #(
  parameter int NUM_SETS = 4,
  parameter int CAPACITY = 256
) (
  input  logic clk,
  input  logic rst,
  bse_req_if   req,
  bse_rsp_if   rsp,
  output int   mismatches,
  output int   pending,
  output int   responses,
  output int   true_flags,
  output int   error_status
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [255:0]  set_map [NUM_SETS];
  logic [8:0]    set_count [NUM_SETS];
  bse_pkg::rsp_t expected_rsp [$];

  function automatic bse_pkg::rsp_t apply_request(input bse_pkg::req_t r);
    bse_pkg::rsp_t res;
    logic [255:0]  x;
    logic [255:0]  y;
    logic [255:0]  z;
    int            n;
    logic          sub;
    res = '0;
    if (r.command > bse_pkg::CMD_READ || r.slot_a >= NUM_SETS ||
        ((r.command == bse_pkg::CMD_COMBINE || r.command == bse_pkg::CMD_COMPARE) &&
         r.slot_b >= NUM_SETS) ||
        (r.command == bse_pkg::CMD_COMBINE && r.dest_slot >= NUM_SETS)) begin
      res.status = 1'b1;
      return res;
    end
    x = set_map[r.slot_a];
    y = set_map[r.slot_b];
    case (r.command)
      bse_pkg::CMD_CLEAR: begin
        set_map[r.slot_a]   = '0;
        set_count[r.slot_a] = '0;
      end
      bse_pkg::CMD_INSERT: begin
        if (!x[r.value]) begin
          if (set_count[r.slot_a] >= CAPACITY) begin
            res.status = 1'b1;
          end else begin
            set_map[r.slot_a][r.value] = 1'b1;
            set_count[r.slot_a]++;
          end
        end
      end
      bse_pkg::CMD_APPEND: begin
        if (set_count[r.slot_a] >= CAPACITY) begin
          res.status = 1'b1;
        end else if (!x[r.value]) begin
          set_map[r.slot_a][r.value] = 1'b1;
          set_count[r.slot_a]++;
        end
      end
      bse_pkg::CMD_REMOVE: begin
        if (x[r.value]) begin
          set_map[r.slot_a][r.value] = 1'b0;
          set_count[r.slot_a]--;
        end
      end
      bse_pkg::CMD_COMBINE: begin
        if (r.op == bse_pkg::OP_BAD) begin
          res.status = 1'b1;
        end else begin
          z = (r.op == bse_pkg::OP_AND) ? (x & y) : (r.op == bse_pkg::OP_OR) ? (x | y)
                                                                              : (x & ~y);
          n = $countones(z);
          if (n > CAPACITY) begin
            res.status = 1'b1;
          end else begin
            set_map[r.dest_slot]   = z;
            set_count[r.dest_slot] = 9'(n);
          end
        end
      end
      bse_pkg::CMD_COMPARE: begin
        sub = ((x & ~y) == '0);
        case (r.op)
          bse_pkg::OP_SUBSET: res.flag = sub;
          bse_pkg::OP_EQUAL:
            res.flag = (x == y) && (set_count[r.slot_a] == set_count[r.slot_b]);
          bse_pkg::OP_PROPER:
            res.flag = sub && (set_count[r.slot_a] < set_count[r.slot_b]);
          default:   res.status = 1'b1;
        endcase
      end
      default: begin
        res.member_word = x[64*r.word_index +: 64];
      end
    endcase
    res.count = (r.command == bse_pkg::CMD_COMBINE) ? set_count[r.dest_slot]
                                                    : set_count[r.slot_a];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_proc
    bse_pkg::rsp_t want;
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        set_map[s]   = '0;
        set_count[s] = '0;
      end
      expected_rsp.delete();
      mismatches   = 0;
      responses    = 0;
      true_flags   = 0;
      error_status = 0;
      pending     <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding, word", rsp.data.member_word,
                          '0);
        end else begin
          want = expected_rsp.pop_front();
          responses++;
          true_flags   += want.flag;
          error_status += want.status;
          if (rsp.data.status !== want.status)
            report_mismatch("status", rsp.data.status, want.status);
          if (rsp.data.flag !== want.flag)
            report_mismatch("flag", rsp.data.flag, want.flag);
          if (rsp.data.count !== want.count)
            report_mismatch("count", rsp.data.count, want.count);
          if (rsp.data.member_word !== want.member_word)
            report_mismatch("member_word", rsp.data.member_word, want.member_word);
        end
      end
      if (req.valid && req.ready) begin
        expected_rsp.push_back(apply_request(req.data));
      end
      pending <= expected_rsp.size();
    end
  end

endmodule

[sim/tb_byte_set_engine_unit.sv]
// Testbench top for the byte set engine: clock, reset, request stimulus, response back-pressure.
module tb_byte_set_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SETS           = 4;
  localparam int         SET_CAPACITY   = 256;
  localparam int         RX_HOLD_CYCLES = 80;
  localparam logic [2:0] CMD_UNDEFINED  = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic hold_rx = 1'b0;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   requests_sent;
  int   mismatches;
  int   pending;
  int   responses;
  int   true_flags;
  int   error_status;

  bse_req_if req_ch ();
  bse_rsp_if rsp_ch ();

  byte_set_engine_unit #(
    .NUM_SETS(SETS),
    .CAPACITY(SET_CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  bse_checker #(
    .NUM_SETS(SETS),
    .CAPACITY(SET_CAPACITY)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .pending(pending),
    .responses(responses),
    .true_flags(true_flags),
    .error_status(error_status)
  );

  always #4 clk = ~clk;

  // far beyond the slowest expected run
  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : response_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic bse_pkg::req_t make_req(input logic [2:0] cmd, input logic [1:0] a,
                                             input logic [1:0] b, input logic [1:0] d,
                                             input logic [1:0] op, input logic [7:0] v,
                                             input logic [1:0] wi);
    bse_pkg::req_t r;
    r.command    = cmd;
    r.slot_a     = a;
    r.slot_b     = b;
    r.dest_slot  = d;
    r.op         = op;
    r.value      = v;
    r.word_index = wi;
    return r;
  endfunction

  // half the values come from the two ends of the byte range so removes and duplicates hit
  function automatic logic [7:0] pick_value();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(15));
      1:       return 8'(240 + $urandom_range(15));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    return ($urandom_range(19) == 0) ? bse_pkg::OP_BAD : 2'($urandom_range(2));
  endfunction

  function automatic bse_pkg::req_t random_req();
    bse_pkg::req_t                    r;
    logic [$bits(bse_pkg::req_t)-1:0] raw;
    int                               pick;
    raw  = $bits(bse_pkg::req_t)'($urandom);
    r    = raw;
    pick = $urandom_range(99);
    if (pick < 4)       r.command = bse_pkg::CMD_CLEAR;
    else if (pick < 29) r.command = bse_pkg::CMD_INSERT;
    else if (pick < 44) r.command = bse_pkg::CMD_APPEND;
    else if (pick < 59) r.command = bse_pkg::CMD_REMOVE;
    else if (pick < 72) r.command = bse_pkg::CMD_COMBINE;
    else if (pick < 85) r.command = bse_pkg::CMD_COMPARE;
    else if (pick < 97) r.command = bse_pkg::CMD_READ;
    else                r.command = CMD_UNDEFINED;
    r.value = pick_value();
    r.op    = pick_op();
    return r;
  endfunction

  task automatic send_request(input bse_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_burst();
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] d;
    int         kind;
    int         n;
    a    = 2'($urandom_range(3));
    b    = 2'($urandom_range(3));
    d    = 2'($urandom_range(3));
    kind = $urandom_range(9);
    if (kind < 4) begin
      send_request(random_req());
    end else if (kind < 7) begin
      // rebuild a slot, then query it
      send_request(make_req(bse_pkg::CMD_CLEAR, a, b, d, pick_op(), pick_value(),
                            2'($urandom)));
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_request(make_req(($urandom_range(1) == 0) ? bse_pkg::CMD_INSERT
                                                       : bse_pkg::CMD_APPEND, a, b, d,
                              pick_op(), pick_value(), 2'($urandom)));
      end
      send_request(make_req(bse_pkg::CMD_COMPARE, a, b, d, pick_op(), pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_READ, a, b, d, pick_op(), pick_value(),
                            2'($urandom)));
    end else begin
      // copy a slot, compare the copy, grow it, compare again, combine it into the first, read it
      send_request(make_req(bse_pkg::CMD_COMBINE, a, a, d, bse_pkg::OP_OR, pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_COMPARE, a, d, b, bse_pkg::OP_EQUAL, pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_INSERT, d, b, a, pick_op(), pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_COMPARE, a, d, b, bse_pkg::OP_PROPER, pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_COMBINE, d, b, a, pick_op(), pick_value(),
                            2'($urandom)));
      send_request(make_req(bse_pkg::CMD_READ, d, b, a, pick_op(), pick_value(),
                            2'($urandom)));
    end
  endtask

  initial begin : stimulus
    logic [7:0] fill_order [256];
    logic [7:0] tmp;
    int         j;
    int         base;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    tx_idle_pct    = 25;
    rx_idle_pct    = 51;
    requests_sent  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(make_req(bse_pkg::CMD_READ,    0, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  0, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  0, 0, 0, bse_pkg::OP_AND,    8'd255, 2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  0, 0, 0, bse_pkg::OP_AND,    8'd255, 2'd0));
    send_request(make_req(bse_pkg::CMD_APPEND,  0, 0, 0, bse_pkg::OP_AND,    8'd128, 2'd0));
    send_request(make_req(bse_pkg::CMD_APPEND,  0, 0, 0, bse_pkg::OP_AND,    8'd128, 2'd0));
    send_request(make_req(bse_pkg::CMD_REMOVE,  0, 0, 0, bse_pkg::OP_AND,    8'd77,  2'd0));
    send_request(make_req(bse_pkg::CMD_REMOVE,  0, 0, 0, bse_pkg::OP_AND,    8'd128, 2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  1, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  1, 0, 0, bse_pkg::OP_AND,    8'd63,  2'd0));
    send_request(make_req(bse_pkg::CMD_READ,    0, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd3));
    send_request(make_req(bse_pkg::CMD_READ,    1, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMBINE, 0, 1, 2, bse_pkg::OP_AND,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMBINE, 0, 1, 3, bse_pkg::OP_OR,     8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMBINE, 0, 1, 0, bse_pkg::OP_DIFF,   8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMBINE, 3, 1, 2, bse_pkg::OP_BAD,    8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 2, 1, 0, bse_pkg::OP_SUBSET, 8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 1, 1, 0, bse_pkg::OP_EQUAL,  8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 2, 1, 0, bse_pkg::OP_PROPER, 8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 2, 1, 0, bse_pkg::OP_BAD,    8'd0,   2'd0));
    send_request(make_req(CMD_UNDEFINED,        3, 3, 3, bse_pkg::OP_BAD,    8'd255, 2'd3));
    send_request(make_req(bse_pkg::CMD_READ,    3, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd2));
    send_request(make_req(bse_pkg::CMD_CLEAR,   3, 0, 0, bse_pkg::OP_AND,    8'd0,   2'd0));

    // fill slot 3 with every byte in random order, then work at capacity
    for (int i = 0; i < 256; i++) fill_order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j             = $urandom_range(i);
      tmp           = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    for (int i = 0; i < 256; i++) begin
      send_request(make_req(bse_pkg::CMD_INSERT, 3, 0, 0, bse_pkg::OP_AND, fill_order[i],
                            2'd0));
    end
    send_request(make_req(bse_pkg::CMD_APPEND,  3, 0, 0, bse_pkg::OP_AND,    8'd5,   2'd0));
    send_request(make_req(bse_pkg::CMD_INSERT,  3, 0, 0, bse_pkg::OP_AND,    8'd200, 2'd0));
    for (int w = 0; w < 4; w++) begin
      send_request(make_req(bse_pkg::CMD_READ,  3, 0, 0, bse_pkg::OP_AND,    8'd0,   2'(w)));
    end
    send_request(make_req(bse_pkg::CMD_COMBINE, 3, 0, 1, bse_pkg::OP_OR,     8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 3, 1, 0, bse_pkg::OP_EQUAL,  8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 0, 3, 0, bse_pkg::OP_PROPER, 8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_REMOVE,  3, 0, 0, bse_pkg::OP_AND,    fill_order[0],
                          2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 3, 1, 0, bse_pkg::OP_PROPER, 8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_APPEND,  3, 0, 0, bse_pkg::OP_AND,    fill_order[0],
                          2'd0));
    send_request(make_req(bse_pkg::CMD_COMBINE, 3, 3, 2, bse_pkg::OP_DIFF,   8'd0,   2'd0));
    send_request(make_req(bse_pkg::CMD_COMPARE, 2, 3, 0, bse_pkg::OP_SUBSET, 8'd0,   2'd0));

    base = requests_sent;
    while (requests_sent < base + 36) random_burst();
    wait_drained();
    tx_idle_pct = 51;
    rx_idle_pct = 25;
    while (requests_sent < base + 72) random_burst();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_rx     = 1'b1;
    repeat (6) send_request(random_req());
    while (requests_sent < base + 108) random_burst();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("summary: %0d requests, %0d responses checked, %0d compares true, %0d errors",
             requests_sent, responses, true_flags, error_status);
    $display("summary: all commands and ops incl. undefined codes, a full set at capacity, "
             , "long response stall");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
